// ===== hw/rtl/rbsf_pkg.sv =====
package rbsf_pkg;

  localparam int CFG_INDEX_WIDTH = 2;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t CFG_IDX_FILTER_MODE = 2'd0;
  localparam cfg_index_t CFG_IDX_COEF_STATE  = 2'd1;
  localparam cfg_index_t CFG_IDX_COEF_INPUT  = 2'd2;

  typedef enum logic {
    MODE_DIFFERENCE = 1'b0,
    MODE_WEIGHTED   = 1'b1
  } filter_mode_t;

  localparam int COEF_STATE_RESET = 60621;
  localparam int COEF_INPUT_RESET = 63078;

endpackage

// ===== hw/rtl/rbsf_in_if.sv =====
interface rbsf_in_if #(
  parameter int FLOW_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [FLOW_WIDTH-1:0] flow_sample;
  logic                  sample_missing;
  logic                  series_start;

  modport source (output valid, output flow_sample, output sample_missing,
                  output series_start, input ready);
  modport sink   (input valid, input flow_sample, input sample_missing,
                  input series_start, output ready);
endinterface

// ===== hw/rtl/rbsf_out_if.sv =====
interface rbsf_out_if #(
  parameter int FLOW_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [FLOW_WIDTH:0]   baseflow_value;
  logic                         result_missing;

  modport source (output valid, output baseflow_value, output result_missing,
                  input ready);
  modport sink   (input valid, input baseflow_value, input result_missing,
                  output ready);
endinterface

// ===== hw/rtl/rbsf_cfg_if.sv =====
interface rbsf_cfg_if
  import rbsf_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16
);
  logic                      valid;
  logic                      ready;
  cfg_index_t                index;
  logic [COEF_FRAC_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rbsf_cfg_regs.sv =====
module rbsf_cfg_regs
  import rbsf_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rbsf_cfg_if.sink                  cfg_ch,
  output filter_mode_t              filter_mode,
  output logic [COEF_FRAC_BITS-1:0] coef_state,
  output logic [COEF_FRAC_BITS-1:0] coef_input
);

  localparam logic [COEF_FRAC_BITS-1:0] COEF_STATE_INIT = COEF_FRAC_BITS'(COEF_STATE_RESET);
  localparam logic [COEF_FRAC_BITS-1:0] COEF_INPUT_INIT = COEF_FRAC_BITS'(COEF_INPUT_RESET);

  filter_mode_t              filter_mode_r;
  logic [COEF_FRAC_BITS-1:0] coef_state_r;
  logic [COEF_FRAC_BITS-1:0] coef_input_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= MODE_DIFFERENCE;
      coef_state_r  <= COEF_STATE_INIT;
      coef_input_r  <= COEF_INPUT_INIT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_IDX_FILTER_MODE: filter_mode_r <= filter_mode_t'(cfg_ch.data[0]);
        CFG_IDX_COEF_STATE:  coef_state_r  <= cfg_ch.data;
        CFG_IDX_COEF_INPUT:  coef_input_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign filter_mode = filter_mode_r;
  assign coef_state  = coef_state_r;
  assign coef_input  = coef_input_r;

endmodule

// ===== hw/rtl/rbsf_datapath.sv =====
module rbsf_datapath
  import rbsf_pkg::*;
#(
  parameter int FLOW_WIDTH     = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        update_en,
  input  filter_mode_t                filter_mode,
  input  logic [COEF_FRAC_BITS-1:0]   coef_state,
  input  logic [COEF_FRAC_BITS-1:0]   coef_input,
  input  logic [FLOW_WIDTH-1:0]       flow,
  input  logic                        missing,
  input  logic                        start,
  output logic signed [FLOW_WIDTH:0]  base_out,
  output logic                        missing_out
);

  localparam int W  = FLOW_WIDTH;
  localparam int F  = COEF_FRAC_BITS;
  localparam int PW = W + F;
  localparam int IW = W + F + 2;
  localparam int AW = W + F + 3;
  localparam int RW = AW - F;
  localparam logic [AW-1:0] HALF = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  logic [W-1:0] filter_value_r, filter_value_nxt;
  logic [W-1:0] prev_flow_r;
  logic         prev_missing_r;

  logic                 restart;
  logic [PW-1:0]        prod_s;
  logic signed [W:0]    opnd;
  logic signed [IW-1:0] prod_i;
  logic signed [AW-1:0] acc;
  logic [AW-1:0]        rnd_sum;
  logic [RW-1:0]        rnd;
  logic                 acc_nonpos;
  logic                 rnd_high;
  logic [W-1:0]         quick;
  logic [W-1:0]         base_w;

  assign restart = start || prev_missing_r;

  always_comb begin
    prod_s = PW'(coef_state) * PW'(filter_value_r);
    if (filter_mode == MODE_WEIGHTED) begin
      opnd = $signed({1'b0, flow});
    end else begin
      opnd = $signed({1'b0, flow}) - $signed({1'b0, prev_flow_r});
    end
    prod_i  = $signed({{(IW-F){1'b0}}, coef_input}) * $signed({{(IW-W-1){opnd[W]}}, opnd});
    acc     = $signed({3'b000, prod_s}) + $signed({prod_i[IW-1], prod_i});
    rnd_sum = acc + HALF;
    rnd     = rnd_sum[AW-1:F];
    acc_nonpos = acc[AW-1] || (acc == '0);
    rnd_high   = |rnd[RW-1:W];

    // quickflow: zero floor, saturate at full scale
    if (acc_nonpos) begin
      quick = '0;
    end else if (rnd_high) begin
      quick = '1;
    end else begin
      quick = rnd[W-1:0];
    end

    // weighted baseflow never exceeds the flow
    if (rnd_high || (rnd[W-1:0] > flow)) begin
      base_w = flow;
    end else begin
      base_w = rnd[W-1:0];
    end

    if (filter_mode == MODE_WEIGHTED) begin
      filter_value_nxt = restart ? flow : base_w;
      base_out         = $signed({1'b0, filter_value_nxt});
    end else begin
      filter_value_nxt = restart ? '0 : quick;
      base_out         = $signed({1'b0, flow}) - $signed({1'b0, filter_value_nxt});
    end
    missing_out = missing;
    if (missing) begin
      base_out = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_value_r <= '0;
      prev_flow_r    <= '0;
      prev_missing_r <= 1'b1;
    end else if (update_en) begin
      if (missing) begin
        prev_missing_r <= 1'b1;
      end else begin
        filter_value_r <= filter_value_nxt;
        prev_flow_r    <= flow;
        prev_missing_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/recursive_baseflow_separation_filter.sv =====
// channel   dir  payload                                handshake
// in_ch     in   flow_sample, sample_missing, series_start valid/ready
// out_ch    out  baseflow_value, result_missing         valid/ready
// cfg_ch    in   index, data                            valid/ready (ready always high)
//
// one beat in and one beat out per cycle while out_ch.ready is high; an input beat is
// held in the input stage, then moves to the output register and waits for out_ch.ready
// the filter state update and both multiplies sit between the input and output registers
// rst_n is synchronous: both stages empty, state cleared, weights at their defaults
// a stalled output holds the input stage; in_ch.ready stays high while the input stage
// is empty or moving into the output register
module recursive_baseflow_separation_filter
  import rbsf_pkg::*;
#(
  parameter int FLOW_WIDTH     = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  rbsf_in_if.sink    in_ch,
  rbsf_out_if.source out_ch,
  rbsf_cfg_if.sink   cfg_ch
);

  filter_mode_t              filter_mode;
  logic [COEF_FRAC_BITS-1:0] coef_state;
  logic [COEF_FRAC_BITS-1:0] coef_input;

  logic                  s1_valid_r;
  logic [FLOW_WIDTH-1:0] s1_flow_r;
  logic                  s1_missing_r;
  logic                  s1_start_r;

  logic                       out_valid_r;
  logic signed [FLOW_WIDTH:0] out_base_r;
  logic                       out_missing_r;

  logic                       out_adv;
  logic                       s1_move;
  logic signed [FLOW_WIDTH:0] base_calc;
  logic                       missing_calc;

  rbsf_cfg_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .filter_mode(filter_mode),
    .coef_state (coef_state),
    .coef_input (coef_input)
  );

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_move     = s1_valid_r && out_adv;
  assign in_ch.ready = !s1_valid_r || out_adv;

  rbsf_datapath #(
    .FLOW_WIDTH    (FLOW_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .update_en  (s1_move),
    .filter_mode(filter_mode),
    .coef_state (coef_state),
    .coef_input (coef_input),
    .flow       (s1_flow_r),
    .missing    (s1_missing_r),
    .start      (s1_start_r),
    .base_out   (base_calc),
    .missing_out(missing_calc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_flow_r    <= in_ch.flow_sample;
      s1_missing_r <= in_ch.sample_missing;
      s1_start_r   <= in_ch.series_start;
    end
    if (s1_move) begin
      out_base_r    <= base_calc;
      out_missing_r <= missing_calc;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.baseflow_value = out_base_r;
  assign out_ch.result_missing = out_missing_r;

endmodule
